### design/c2p_pkg.sv
// Shared constants and the arctangent table for the cartesian-to-polar pipeline.
// No dependencies; every other design file imports this package.
package c2p_pkg;

    // Default configuration of the top level
    localparam int COORD_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF  = 16;

    // Fixed-point layout of the rotation datapath
    localparam int FRAC_BITS = 24;  // fraction bits of x and y
    localparam int GUARD_W   = 3;   // growth headroom of x and y
    localparam int ATAN_LEN  = 24;  // entries in the arctangent table
    localparam int Z_W       = 34;  // angle accumulator, units of pi/2^31

    // Result word fields
    localparam int RADIUS_W = 17;
    localparam int ANGLE_W  = 17;

    // Angle constants in accumulator units
    localparam logic signed [Z_W-1:0] Z_PI       = Z_W'(64'h0000_0000_8000_0000);
    localparam logic signed [Z_W-1:0] Z_HALF_LSB = Z_W'(64'h0000_0000_0000_8000);
    // Output angle limit, pi in units of pi/32768
    localparam logic signed [Z_W-1:0] ANGLE_LIMIT = Z_W'(64'h0000_0000_0000_8000);

    // atan(2^-i) in units of pi/2^31, rounded to nearest
    function automatic logic [Z_W-1:0] atan_entry(input int idx);
        logic [Z_W-1:0] val;
        begin
            case (idx)
                0:       val = Z_W'(536870912);
                1:       val = Z_W'(316933406);
                2:       val = Z_W'(167458907);
                3:       val = Z_W'(85004756);
                4:       val = Z_W'(42667331);
                5:       val = Z_W'(21354465);
                6:       val = Z_W'(10679838);
                7:       val = Z_W'(5340245);
                8:       val = Z_W'(2670163);
                9:       val = Z_W'(1335087);
                10:      val = Z_W'(667544);
                11:      val = Z_W'(333772);
                12:      val = Z_W'(166886);
                13:      val = Z_W'(83443);
                14:      val = Z_W'(41722);
                15:      val = Z_W'(20861);
                16:      val = Z_W'(10430);
                17:      val = Z_W'(5215);
                18:      val = Z_W'(2608);
                19:      val = Z_W'(1304);
                20:      val = Z_W'(652);
                21:      val = Z_W'(326);
                22:      val = Z_W'(163);
                23:      val = Z_W'(81);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

### design/c2p_front.sv
// Front end of the pipeline: difference vector, half-plane fold, squares and their sum.
// Depends on c2p_pkg.
module c2p_front #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                       aclk,
    input  logic                                                       aresetn,
    input  logic                                                       adv,
    input  logic                                                       in_valid,
    input  logic signed [COORD_WIDTH-1:0]                              point_x,
    input  logic signed [COORD_WIDTH-1:0]                              point_y,
    input  logic signed [COORD_WIDTH-1:0]                              origin_x,
    input  logic signed [COORD_WIDTH-1:0]                              origin_y,
    output logic                                                       out_valid,
    output logic signed [COORD_WIDTH+c2p_pkg::FRAC_BITS+c2p_pkg::GUARD_W:0] out_x,
    output logic signed [COORD_WIDTH+c2p_pkg::FRAC_BITS+c2p_pkg::GUARD_W:0] out_y,
    output logic signed [c2p_pkg::Z_W-1:0]                             out_z,
    output logic                                                       out_zero,
    output logic [2*COORD_WIDTH+1:0]                                   out_n
);
    import c2p_pkg::*;

    localparam int DW = COORD_WIDTH + 1;          // difference width
    localparam int W  = DW + FRAC_BITS + GUARD_W; // rotation datapath width
    localparam int NW = 2 * DW;                   // sum of squares width

    // Stage 0: difference vector
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [DW-1:0] dx_next, dy_next;
    logic                 v0_reg;

    // Stage 1: folded vector and squares
    logic signed [W-1:0]   x1_reg, y1_reg;
    logic signed [W-1:0]   x1_next, y1_next;
    logic signed [Z_W-1:0] z1_reg, z1_next;
    logic                  zero1_reg, zero1_next;
    logic [NW-1:0]         sqx_reg, sqy_reg;
    logic [NW-1:0]         sqx_next, sqy_next;
    logic                  v1_reg;

    // Stage 2: sum of squares
    logic signed [W-1:0]   x2_reg, y2_reg;
    logic signed [Z_W-1:0] z2_reg;
    logic                  zero2_reg;
    logic [NW-1:0]         n2_reg, n2_next;
    logic                  v2_reg;

    logic signed [W-1:0] x_pre, y_pre;
    logic [DW-1:0]       ax, ay;

    // Form the differences one bit wider than the coordinates
    always_comb begin
        dx_next = $signed({point_x[COORD_WIDTH-1], point_x})
                - $signed({origin_x[COORD_WIDTH-1], origin_x});
        dy_next = $signed({point_y[COORD_WIDTH-1], point_y})
                - $signed({origin_y[COORD_WIDTH-1], origin_y});
    end

    // Scale, fold the left half-plane by pi, and square the magnitudes
    always_comb begin
        x_pre = $signed({{GUARD_W{dx_reg[DW-1]}}, dx_reg, {FRAC_BITS{1'b0}}});
        y_pre = $signed({{GUARD_W{dy_reg[DW-1]}}, dy_reg, {FRAC_BITS{1'b0}}});
        if (dx_reg[DW-1]) begin
            x1_next = -x_pre;
            y1_next = -y_pre;
            z1_next = dy_reg[DW-1] ? -Z_PI : Z_PI;
        end else begin
            x1_next = x_pre;
            y1_next = y_pre;
            z1_next = '0;
        end
        zero1_next = (dx_reg == '0) && (dy_reg == '0);
        ax         = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ay         = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        sqx_next   = NW'(ax) * NW'(ax);
        sqy_next   = NW'(ay) * NW'(ay);
        n2_next    = sqx_reg + sqy_reg;
    end

    // Advance payload with the pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            z1_reg    <= z1_next;
            zero1_reg <= zero1_next;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            zero2_reg <= zero1_reg;
            n2_reg    <= n2_next;
        end
    end

    // Advance the valid bits; reset drops them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_x     = x2_reg;
    assign out_y     = y2_reg;
    assign out_z     = z2_reg;
    assign out_zero  = zero2_reg;
    assign out_n     = n2_reg;

endmodule

### design/c2p_cell.sv
// One cell of the row: a vectoring micro-rotation and one square-root digit, as DO_ROT and DO_ROOT enable.
// Depends on c2p_pkg.
module c2p_cell #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
    parameter int STEP        = 0,
    parameter bit DO_ROT      = 1'b1,
    parameter bit DO_ROOT     = 1'b1
) (
    input  logic                                                       aclk,
    input  logic                                                       aresetn,
    input  logic                                                       adv,
    input  logic                                                       in_valid,
    input  logic signed [COORD_WIDTH+c2p_pkg::FRAC_BITS+c2p_pkg::GUARD_W:0] in_x,
    input  logic signed [COORD_WIDTH+c2p_pkg::FRAC_BITS+c2p_pkg::GUARD_W:0] in_y,
    input  logic signed [c2p_pkg::Z_W-1:0]                             in_z,
    input  logic                                                       in_zero,
    input  logic [2*COORD_WIDTH+1:0]                                   in_n,
    input  logic [COORD_WIDTH+2:0]                                     in_r,
    input  logic [COORD_WIDTH:0]                                       in_q,
    output logic                                                       out_valid,
    output logic signed [COORD_WIDTH+c2p_pkg::FRAC_BITS+c2p_pkg::GUARD_W:0] out_x,
    output logic signed [COORD_WIDTH+c2p_pkg::FRAC_BITS+c2p_pkg::GUARD_W:0] out_y,
    output logic signed [c2p_pkg::Z_W-1:0]                             out_z,
    output logic                                                       out_zero,
    output logic [2*COORD_WIDTH+1:0]                                   out_n,
    output logic [COORD_WIDTH+2:0]                                     out_r,
    output logic [COORD_WIDTH:0]                                       out_q
);
    import c2p_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int W  = DW + FRAC_BITS + GUARD_W;
    localparam int NW = 2 * DW;   // radicand width
    localparam int SW = DW;       // root width
    localparam int RW = SW + 2;   // remainder width
    localparam logic [Z_W-1:0] ATAN_STEP = atan_entry(STEP);

    logic signed [W-1:0]   x_reg, y_reg, x_next, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic                  zero_reg;
    logic [NW-1:0]         n_reg, n_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [SW-1:0]         q_reg, q_next;
    logic                  valid_reg;

    logic signed [W-1:0] xs, ys;
    logic [RW-1:0]       r_sh, trial;
    logic                take;

    // Micro-rotation: drive y toward zero, floor shifts by STEP
    always_comb begin
        xs = in_x >>> STEP;
        ys = in_y >>> STEP;
        if (!DO_ROT) begin
            x_next = in_x;
            y_next = in_y;
            z_next = in_z;
        end else if (!in_y[W-1] && (in_y != '0)) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + $signed(ATAN_STEP);
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - $signed(ATAN_STEP);
        end
    end

    // Root digit: bring down two radicand bits, try q*4+1
    always_comb begin
        r_sh  = {in_r[RW-3:0], in_n[NW-1:NW-2]};
        trial = {in_q, 2'b01};
        take  = (r_sh >= trial);
        if (!DO_ROOT) begin
            r_next = in_r;
            q_next = in_q;
            n_next = in_n;
        end else begin
            r_next = take ? (r_sh - trial) : r_sh;
            q_next = {in_q[SW-2:0], take};
            n_next = {in_n[NW-3:0], 2'b00};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= in_zero;
            n_reg    <= n_next;
            r_reg    <= r_next;
            q_reg    <= q_next;
        end
    end

    // Advance the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_zero  = zero_reg;
    assign out_n     = n_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;

endmodule

### design/c2p_back.sv
// Back end: rounds the angle and the root, and holds the result word for the consumer.
// Depends on c2p_pkg.
module c2p_back #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  logic signed [c2p_pkg::Z_W-1:0]       in_z,
    input  logic                                 in_zero,
    input  logic [COORD_WIDTH+2:0]               in_r,
    input  logic [COORD_WIDTH:0]                 in_q,
    output logic                                 out_valid,
    output logic [c2p_pkg::RADIUS_W-1:0]         out_radius,
    output logic signed [c2p_pkg::ANGLE_W-1:0]   out_angle
);
    import c2p_pkg::*;

    localparam int SW   = COORD_WIDTH + 1;
    localparam int RW   = SW + 2;
    localparam int RADW = (SW + 1 > RADIUS_W) ? SW + 1 : RADIUS_W;

    logic                        valid_reg;
    logic [RADIUS_W-1:0]         radius_reg, radius_next;
    logic signed [ANGLE_W-1:0]   angle_reg, angle_next;

    logic signed [Z_W-1:0] z_rnd, a_full;
    logic                  round_up;
    logic [RADW-1:0]       rad_full;

    // Round half up to pi/32768 units, then limit to plus or minus pi; a zero vector gets angle zero
    always_comb begin
        z_rnd  = in_z + Z_HALF_LSB;
        a_full = z_rnd >>> 16;
        if (in_zero) begin
            angle_next = '0;
        end else if (a_full > ANGLE_LIMIT) begin
            angle_next = ANGLE_W'(ANGLE_LIMIT);
        end else if (a_full < -ANGLE_LIMIT) begin
            angle_next = ANGLE_W'(-ANGLE_LIMIT);
        end else begin
            angle_next = ANGLE_W'(a_full);
        end
    end

    // Round the root up when the remainder exceeds it
    always_comb begin
        round_up    = (in_r > RW'(in_q));
        rad_full    = RADW'(in_q) + RADW'(round_up);
        radius_next = rad_full[RADIUS_W-1:0];
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (adv) begin
            radius_reg <= radius_next;
            angle_reg  <= angle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid  = valid_reg;
    assign out_radius = radius_reg;
    assign out_angle  = angle_reg;

endmodule

### design/cartesian_to_polar.sv
// Top level of the cartesian-to-polar converter: front end, row of cells, back end.
// Depends on c2p_pkg, c2p_front, c2p_cell and c2p_back.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   point_x, point_y, origin_x, origin_y
//   m_        out        m_valid / m_ready   radius, angle
//
// One word enters per cycle while the output is not stalled; each result passes through
// three front stages, one cell per micro-rotation or root digit, whichever row is
// longer, and the output register.
// The whole pipeline advances whenever the output register is empty or being taken;
// a stalled m_ready holds every stage and drops s_ready in the same cycle.
// aresetn (synchronous) clears all valid bits; payload registers are not reset.
module cartesian_to_polar #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ITERATIONS  = c2p_pkg::ITERATIONS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_point_x,
    input  logic signed [COORD_WIDTH-1:0]        s_point_y,
    input  logic signed [COORD_WIDTH-1:0]        s_origin_x,
    input  logic signed [COORD_WIDTH-1:0]        s_origin_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [c2p_pkg::RADIUS_W-1:0]         m_radius,
    output logic signed [c2p_pkg::ANGLE_W-1:0]   m_angle
);
    import c2p_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int W  = DW + FRAC_BITS + GUARD_W;
    localparam int NW = 2 * DW;
    localparam int SW = DW;
    localparam int RW = SW + 2;
    localparam int NC = (ITERATIONS > SW) ? ITERATIONS : SW;

    logic adv;

    // Taps between the cells of the row
    logic                  v_c    [0:NC];
    logic signed [W-1:0]   x_c    [0:NC];
    logic signed [W-1:0]   y_c    [0:NC];
    logic signed [Z_W-1:0] z_c    [0:NC];
    logic                  zero_c [0:NC];
    logic [NW-1:0]         n_c    [0:NC];
    logic [RW-1:0]         r_c    [0:NC];
    logic [SW-1:0]         q_c    [0:NC];

    // Advance everything when the output register is free or being taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    c2p_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .point_x   (s_point_x),
        .point_y   (s_point_y),
        .origin_x  (s_origin_x),
        .origin_y  (s_origin_y),
        .out_valid (v_c[0]),
        .out_x     (x_c[0]),
        .out_y     (y_c[0]),
        .out_z     (z_c[0]),
        .out_zero  (zero_c[0]),
        .out_n     (n_c[0])
    );

    // Root remainder and root start empty
    assign r_c[0] = '0;
    assign q_c[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        c2p_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .STEP        (k),
            .DO_ROT      ((k < ITERATIONS) && (k < ATAN_LEN)),
            .DO_ROOT     (k < SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v_c[k]),
            .in_x      (x_c[k]),
            .in_y      (y_c[k]),
            .in_z      (z_c[k]),
            .in_zero   (zero_c[k]),
            .in_n      (n_c[k]),
            .in_r      (r_c[k]),
            .in_q      (q_c[k]),
            .out_valid (v_c[k+1]),
            .out_x     (x_c[k+1]),
            .out_y     (y_c[k+1]),
            .out_z     (z_c[k+1]),
            .out_zero  (zero_c[k+1]),
            .out_n     (n_c[k+1]),
            .out_r     (r_c[k+1]),
            .out_q     (q_c[k+1])
        );
    end

    c2p_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (v_c[NC]),
        .in_z       (z_c[NC]),
        .in_zero    (zero_c[NC]),
        .in_r       (r_c[NC]),
        .in_q       (q_c[NC]),
        .out_valid  (m_valid),
        .out_radius (m_radius),
        .out_angle  (m_angle)
    );

    // Input side stalls only behind a held result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result word");

    // Angle stays within plus or minus pi
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_angle <= 17'sd32768) && (m_angle >= -17'sd32768)))
        else $error("angle outside plus or minus pi");

    // A zero distance comes from a zero vector, whose angle is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_radius == '0) && (COORD_WIDTH <= 16)) |-> (m_angle == '0))
        else $error("zero radius with nonzero angle");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule
